/* sv/rtcd_pkg.sv */
`default_nettype none

package rtcd_pkg;

   // one raw clock reading
   typedef struct packed {
      logic [6:0] seconds_bcd;
      logic [6:0] minutes_bcd;
      logic [5:0] hours_bcd;
      logic [5:0] day_bcd;
      logic [4:0] month_bcd;
      logic [7:0] year_bcd;
      logic [2:0] weekday;
   } req_type;

   // one display symbol
   typedef struct packed {
      logic [5:0] symbol;
      logic       last;
   } rsp_type;

   // zone-adjusted binary time, passed from front to back
   typedef struct packed {
      logic [5:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
      logic [5:0] day;
      logic [4:0] month;
      logic [6:0] year;
      logic [2:0] weekday;
   } stamp_type;

   localparam logic [5:0] SEP_CODE = 6'd36;
   localparam logic [5:0] END_CODE = 6'd37;
   localparam logic [5:0] D_CODE   = 6'd13;
   localparam logic [5:0] W_CODE   = 6'd32;

   localparam logic [7:0] HOURS_PER_DAY   = 8'd24;
   localparam logic [6:0] DAYS_PER_MONTH  = 7'd31;
   localparam logic [5:0] MONTHS_PER_YEAR = 6'd12;
   localparam logic [7:0] YEARS_PER_CENT  = 8'd100;
   localparam logic [6:0] LAST_YEAR       = 7'd99;
   localparam logic [2:0] LAST_WEEKDAY    = 3'd6;
   localparam logic [2:0] WEEKDAY_SEVEN   = 3'd7;

   // symbol groups in output order
   localparam logic [2:0] FIELD_HOUR   = 3'd0;
   localparam logic [2:0] FIELD_MINUTE = 3'd1;
   localparam logic [2:0] FIELD_SECOND = 3'd2;
   localparam logic [2:0] FIELD_DAY    = 3'd3;
   localparam logic [2:0] FIELD_MONTH  = 3'd4;
   localparam logic [2:0] FIELD_YEAR   = 3'd5;
   localparam logic [2:0] FIELD_TAIL   = 3'd6;

   // position within a two-digit group
   localparam logic [1:0] POS_TENS  = 2'd0;
   localparam logic [1:0] POS_UNITS = 2'd1;
   localparam logic [1:0] POS_SEP   = 2'd2;

   // position within the tail group
   localparam logic [1:0] TAIL_D    = 2'd0;
   localparam logic [1:0] TAIL_W    = 2'd1;
   localparam logic [1:0] TAIL_WDAY = 2'd2;
   localparam logic [1:0] TAIL_END  = 2'd3;

   localparam int         QUEUE_DEPTH = 2;
   localparam logic [1:0] QUEUE_FULL_COUNT = 2'(QUEUE_DEPTH);

   // tens nibble times ten plus units nibble, digits taken at face value
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] raw);
      return {4'b0000, raw[7:4]} * 8'd10 + {4'b0000, raw[3:0]};
   endfunction

   // quotient by ten through a reciprocal, exact for all 7-bit values
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] prod;
      prod = {8'b0, v} * 15'd205;
      return prod[14:11];
   endfunction

endpackage

`default_nettype wire

/* sv/rtcd_front.sv */
`default_nettype none

module rtcd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [4:0]          tz_offset,
   input  wire logic                push,
   input  wire rtcd_pkg::req_type   req_data,
   output logic                     full,
   output logic                     q_push,
   output rtcd_pkg::stamp_type      q_data,
   input  wire logic                q_full
);

   logic       stage_valid_ff, stage_valid_in;
   logic [6:0] sec_ff, sec_in;
   logic [6:0] min_ff, min_in;
   logic [5:0] hr_ff, hr_in;
   logic [5:0] day_ff, day_in;
   logic [4:0] mon_ff, mon_in;
   logic [6:0] yr_ff, yr_in;
   logic [2:0] wd_ff, wd_in;
   logic       accept;

   logic [7:0] sec_bin, min_bin, hr_bin, day_bin, mon_bin, yr_bin, yr_red;

   assign full   = stage_valid_ff && q_full;
   assign accept = push && !full;
   assign q_push = stage_valid_ff && !q_full;

   // bcd to binary on the way in
   always_comb begin
      sec_bin = rtcd_pkg::bcd_to_bin({1'b0, req_data.seconds_bcd});
      min_bin = rtcd_pkg::bcd_to_bin({1'b0, req_data.minutes_bcd});
      hr_bin  = rtcd_pkg::bcd_to_bin({2'b00, req_data.hours_bcd});
      day_bin = rtcd_pkg::bcd_to_bin({2'b00, req_data.day_bcd});
      mon_bin = rtcd_pkg::bcd_to_bin({3'b000, req_data.month_bcd});
      yr_bin  = rtcd_pkg::bcd_to_bin(req_data.year_bcd);
      yr_red  = (yr_bin >= rtcd_pkg::YEARS_PER_CENT) ? yr_bin - rtcd_pkg::YEARS_PER_CENT
                                                     : yr_bin;
      sec_in  = sec_bin[6:0];
      min_in  = min_bin[6:0];
      hr_in   = hr_bin[5:0];
      day_in  = day_bin[5:0];
      mon_in  = mon_bin[4:0];
      yr_in   = yr_red[6:0];
      wd_in   = req_data.weekday;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (q_push) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sec_ff <= sec_in;
         min_ff <= min_in;
         hr_ff  <= hr_in;
         day_ff <= day_in;
         mon_ff <= mon_in;
         yr_ff  <= yr_in;
         wd_ff  <= wd_in;
      end
   end

   // zone shift with borrow or carry through day, month, year, weekday
   logic [7:0] adj;
   logic       borrow, carry;
   logic [7:0] hour_sum;
   logic [6:0] day_next;
   logic [5:0] mon_next;

   always_comb begin
      adj      = {2'b00, hr_ff} + {{3{tz_offset[4]}}, tz_offset};
      borrow   = adj[7];
      carry    = !adj[7] && (adj >= rtcd_pkg::HOURS_PER_DAY);
      day_next = {1'b0, day_ff} + 7'd1;
      mon_next = {1'b0, mon_ff} + 6'd1;

      q_data.minute = min_ff;
      q_data.second = sec_ff;
      q_data.day    = day_ff;
      q_data.month  = mon_ff;
      q_data.year   = yr_ff;
      q_data.weekday = wd_ff;

      priority if (borrow) begin
         hour_sum = adj + rtcd_pkg::HOURS_PER_DAY;
         if (day_ff <= 6'd1) begin
            q_data.day = rtcd_pkg::DAYS_PER_MONTH[5:0];
            if (mon_ff <= 5'd1) begin
               q_data.month = rtcd_pkg::MONTHS_PER_YEAR[4:0];
               q_data.year  = (yr_ff == 7'd0) ? rtcd_pkg::LAST_YEAR : yr_ff - 7'd1;
            end else begin
               q_data.month = mon_ff - 5'd1;
            end
         end else begin
            q_data.day = day_ff - 6'd1;
         end
         q_data.weekday = (wd_ff == 3'd0) ? rtcd_pkg::LAST_WEEKDAY : wd_ff - 3'd1;
      end else if (carry) begin
         hour_sum = adj - rtcd_pkg::HOURS_PER_DAY;
         if (day_next > rtcd_pkg::DAYS_PER_MONTH) begin
            q_data.day = 6'd1;
            if (mon_next > rtcd_pkg::MONTHS_PER_YEAR) begin
               q_data.month = 5'd1;
               q_data.year  = (yr_ff == rtcd_pkg::LAST_YEAR) ? 7'd0 : yr_ff + 7'd1;
            end else begin
               q_data.month = mon_next[4:0];
            end
         end else begin
            q_data.day = day_next[5:0];
         end
         // seven wraps to one, six to zero
         if (wd_ff == rtcd_pkg::WEEKDAY_SEVEN) begin
            q_data.weekday = 3'd1;
         end else if (wd_ff == rtcd_pkg::LAST_WEEKDAY) begin
            q_data.weekday = 3'd0;
         end else begin
            q_data.weekday = wd_ff + 3'd1;
         end
      end else begin
         hour_sum = adj;
      end
      q_data.hour = hour_sum[5:0];
   end

endmodule

`default_nettype wire

/* sv/rtcd_queue.sv */
`default_nettype none

module rtcd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire rtcd_pkg::stamp_type wr_data,
   output logic                     is_full,
   output logic                     not_empty,
   input  wire logic                rd_en,
   output rtcd_pkg::stamp_type      rd_data
);

   rtcd_pkg::stamp_type entry_ff [rtcd_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign is_full   = (count_ff == rtcd_pkg::QUEUE_FULL_COUNT);
   assign not_empty = (count_ff != 2'd0);
   assign rd_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      is_full |-> !wr_en)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !rd_en)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rtcd_pkg::QUEUE_FULL_COUNT)
      else $error("queue count out of range");

endmodule

`default_nettype wire

/* sv/rtcd_back.sv */
`default_nettype none

module rtcd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire rtcd_pkg::stamp_type q_data,
   output logic                     q_pop,
   input  wire logic                pop,
   output logic                     empty,
   output rtcd_pkg::rsp_type        rsp_data
);

   logic [2:0] field_ff, field_in;
   logic [1:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   rtcd_pkg::rsp_type out_ff, out_in;

   logic       advance;
   logic       last_sel;
   logic [6:0] value;
   logic [3:0] tens;
   logic [6:0] tens_x10;
   logic [6:0] units;

   assign empty    = !valid_ff;
   assign rsp_data = out_ff;
   assign advance  = q_valid && (!valid_ff || pop);
   assign last_sel = (field_ff == rtcd_pkg::FIELD_TAIL) && (pos_ff == rtcd_pkg::TAIL_END);
   assign q_pop    = advance && last_sel;

   always_comb begin
      unique case (field_ff)
         rtcd_pkg::FIELD_HOUR:   value = {1'b0, q_data.hour};
         rtcd_pkg::FIELD_MINUTE: value = q_data.minute;
         rtcd_pkg::FIELD_SECOND: value = q_data.second;
         rtcd_pkg::FIELD_DAY:    value = {1'b0, q_data.day};
         rtcd_pkg::FIELD_MONTH:  value = {2'b00, q_data.month};
         rtcd_pkg::FIELD_YEAR:   value = q_data.year;
         default:                value = 7'd0;
      endcase
      tens     = rtcd_pkg::div10(value);
      tens_x10 = {3'b000, tens} * 7'd10;
      units    = value - tens_x10;

      out_in.last = last_sel;
      if (field_ff == rtcd_pkg::FIELD_TAIL) begin
         unique case (pos_ff)
            rtcd_pkg::TAIL_D:    out_in.symbol = rtcd_pkg::D_CODE;
            rtcd_pkg::TAIL_W:    out_in.symbol = rtcd_pkg::W_CODE;
            rtcd_pkg::TAIL_WDAY: out_in.symbol = {3'b000, q_data.weekday};
            default:             out_in.symbol = rtcd_pkg::END_CODE;
         endcase
      end else begin
         unique case (pos_ff)
            rtcd_pkg::POS_TENS:  out_in.symbol = {2'b00, tens};
            rtcd_pkg::POS_UNITS: out_in.symbol = {2'b00, units[3:0]};
            default:             out_in.symbol = rtcd_pkg::SEP_CODE;
         endcase
      end

      field_in = field_ff;
      pos_in   = pos_ff;
      if (advance) begin
         if (last_sel) begin
            field_in = rtcd_pkg::FIELD_HOUR;
            pos_in   = rtcd_pkg::POS_TENS;
         end else if (field_ff != rtcd_pkg::FIELD_TAIL && pos_ff == rtcd_pkg::POS_SEP) begin
            field_in = field_ff + 3'd1;
            pos_in   = rtcd_pkg::POS_TENS;
         end else begin
            pos_in   = pos_ff + 2'd1;
         end
      end

      if (advance) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= rtcd_pkg::FIELD_HOUR;
         pos_ff   <= rtcd_pkg::POS_TENS;
         valid_ff <= 1'b0;
      end else begin
         field_ff <= field_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (field_ff == rtcd_pkg::FIELD_HOUR) && (pos_ff == rtcd_pkg::POS_TENS))
      else $error("sequencer did not restart after end symbol");

endmodule

`default_nettype wire

/* sv/rtc_time_zone_display_digits.sv */
// Formats one raw real-time-clock reading (bcd seconds, minutes, hours, day,
// month, two-digit year and a binary weekday) into 22 display symbols:
// hh : mm : ss : dd : mo : yy : D W weekday end, where ':' is code 36, D is 13,
// W is 32 and end is 37 with last set. The hour is shifted by the signed
// time-zone register (csr_write_data, 5 bits two's complement), borrowing from
// or carrying into day, weekday, month and year; every month counts 31 days and
// the year wraps within 0..99. Both sides look like a queue: a reading goes in
// on push while full is low, a symbol leaves on pop while empty is low. Each
// reading gives 22 output symbols, one per cycle while pop keeps up, set by
// the symbol sequencer in the back end; the front end converts and shifts the
// next reading meanwhile and parks up to two finished readings in a queue, so
// readings stream back to back with no gaps between their symbol runs. A
// reading passes the front-end input stage, the queue and the output
// register. Write the time-zone register only while no reading is in flight.
`default_nettype none

module rtc_time_zone_display_digits (
   input  wire logic              clock,
   input  wire logic              reset,
   // input channel
   input  wire logic              push,
   input  wire rtcd_pkg::req_type req_data,
   output logic                   full,
   // result channel
   output logic                   empty,
   input  wire logic              pop,
   output rtcd_pkg::rsp_type      rsp_data,
   // time-zone register
   input  wire logic              csr_write_en,
   input  wire logic [4:0]        csr_write_data
);

   // time-zone offset in hours, two's complement
   logic [4:0] tz_offset_ff, tz_offset_in;

   // front to queue
   logic                q_push;
   logic                q_full;
   rtcd_pkg::stamp_type q_wr_data;
   // queue to back
   logic                q_valid;
   logic                q_pop;
   rtcd_pkg::stamp_type q_rd_data;

   assign tz_offset_in = csr_write_en ? csr_write_data : tz_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_offset_ff <= 5'd0;
      end else begin
         tz_offset_ff <= tz_offset_in;
      end
   end

   // bcd conversion and zone shift, one reading held in its input stage
   rtcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .tz_offset (tz_offset_ff),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .q_push    (q_push),
      .q_data    (q_wr_data),
      .q_full    (q_full)
   );

   // two finished readings decouple conversion from symbol output
   rtcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (q_push),
      .wr_data   (q_wr_data),
      .is_full   (q_full),
      .not_empty (q_valid),
      .rd_en     (q_pop),
      .rd_data   (q_rd_data)
   );

   // symbol sequencer, registered output, one transfer per cycle while popped
   rtcd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
